### rtl/factor_boundary_refiner_defines.svh
// ----------------------------------------------------------------------------
// Factor boundary refiner assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FACTOR_BOUNDARY_REFINER_DEFINES_SVH
`define FACTOR_BOUNDARY_REFINER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("factor boundary refiner check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("factor boundary refiner check failed");

`endif

### rtl/frb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Factor boundary refiner package
// Item kinds, register map and the sequencer program.
// ----------------------------------------------------------------------------
package frb_pkg;

  localparam int KIND_W = 2;
  localparam int PC_W   = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRST  = 2'd0,
    KIND_LATER  = 2'd1,
    KIND_LENGTH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_STRIDE       = 2'd0,
    REG_FIRST_STRIDE = 2'd1,
    REG_FIRST_MODE   = 2'd2
  } reg_index_t;

  localparam logic [7:0] STRIDE_RESET       = 8'd3;
  localparam logic [7:0] FIRST_STRIDE_RESET = 8'd3;
  localparam logic       FIRST_MODE_RESET   = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_LOAD       = 3'd1,
    OP_COUNT      = 3'd2,
    OP_EMIT_RUN   = 3'd3,
    OP_EMIT_CUR   = 3'd4,
    OP_EMIT_BOUND = 3'd5,
    OP_EMIT_ZERO  = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER      = 4'd0,
    COND_ALWAYS     = 4'd1,
    COND_NO_IN      = 4'd2,
    COND_KIND_FIRST = 4'd3,
    COND_KIND_NONE  = 4'd4,
    COND_MORE       = 4'd5,
    COND_CNT_ZERO   = 4'd6,
    COND_RUN_MORE   = 4'd7,
    COND_LENGTH     = 4'd8,
    COND_NO_N1      = 4'd9
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_COUNT = 4'd3;
  localparam logic [PC_W-1:0] PC_RUN   = 4'd5;
  localparam logic [PC_W-1:0] PC_TAIL  = 4'd6;
  localparam logic [PC_W-1:0] PC_BOUND = 4'd9;
  localparam logic [PC_W-1:0] PC_ZERO  = 4'd10;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: PC_IDLE};
    case (pc)
      4'd0:    w = '{op: OP_LOAD,       cond: COND_NO_IN,      target: PC_IDLE};
      4'd1:    w = '{op: OP_NONE,       cond: COND_KIND_FIRST, target: PC_ZERO};
      4'd2:    w = '{op: OP_NONE,       cond: COND_KIND_NONE,  target: PC_IDLE};
      4'd3:    w = '{op: OP_COUNT,      cond: COND_MORE,       target: PC_COUNT};
      4'd4:    w = '{op: OP_NONE,       cond: COND_CNT_ZERO,   target: PC_TAIL};
      4'd5:    w = '{op: OP_EMIT_RUN,   cond: COND_RUN_MORE,   target: PC_RUN};
      4'd6:    w = '{op: OP_NONE,       cond: COND_LENGTH,     target: PC_IDLE};
      4'd7:    w = '{op: OP_NONE,       cond: COND_NO_N1,      target: PC_BOUND};
      4'd8:    w = '{op: OP_EMIT_CUR,   cond: COND_NEVER,      target: PC_IDLE};
      4'd9:    w = '{op: OP_EMIT_BOUND, cond: COND_ALWAYS,     target: PC_IDLE};
      4'd10:   w = '{op: OP_EMIT_ZERO,  cond: COND_ALWAYS,     target: PC_IDLE};
      default: w = '{op: OP_NONE,       cond: COND_ALWAYS,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/frb_boundary_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary channel
// Carries one boundary or word length word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface frb_boundary_if #(
  parameter int POS_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic [frb_pkg::KIND_W-1:0] kind;
  logic [POS_BITS-1:0]        position;

  modport source (output valid, output kind, output position, input ready);
  modport sink (input valid, input kind, input position, output ready);
endinterface

### rtl/frb_split_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split point channel
// Carries one split point word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface frb_split_if #(
  parameter int POS_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] split_position;
  logic                is_original;
  logic                last;
  logic                clipped;

  modport source (output valid, output split_position, output is_original,
                  output last, output clipped, input ready);
  modport sink (input valid, input split_position, input is_original,
                input last, input clipped, output ready);
endinterface

### rtl/factor_boundary_refiner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Factor boundary refiner
// Inserts artificial split points between the factor boundaries of a word.
// ----------------------------------------------------------------------------
// The boundary channel takes the first boundary of a word, its later
// boundaries in ascending order, and then the word length. The split channel
// returns split points in ascending order, with last marking the final word
// caused by each input word. The APB port writes stride, first_stride and
// first_step_mode; the user must do so only while the block is idle, which
// the block itself does not enforce. A small program steps the datapath: a
// counting loop steps down one stride per cycle from the boundary, or from
// first_stride below a later boundary when first_step_mode is set, to find
// the lowest kept point, then an emit loop walks back up one point per cycle
// while the receiver takes them. One input word is handled at a time; the
// next is taken when the program returns to its first step, which may be
// while the final split word still waits in the output register. When the
// receiver stalls the program holds at its emit step. Reset clears the
// registers to their defaults, the stored boundary to zero and both
// channels to empty.
// ----------------------------------------------------------------------------
`include "factor_boundary_refiner_defines.svh"

module factor_boundary_refiner #(
  parameter int POS_BITS = 16,
  parameter int MAX_RUN  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  frb_boundary_if.sink                boundary,
  frb_split_if.source                 split,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frb_pkg::ADDR_W-1:0]  paddr,
  input  logic [frb_pkg::DATA_W-1:0]  pwdata,
  output logic [frb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);

  logic [7:0]             stride;
  logic [7:0]             first_stride;
  logic                   first_step_mode;
  logic [1:0]             reg_sel;
  logic                   cfg_write;

  logic [frb_pkg::PC_W-1:0] pc;
  logic [frb_pkg::PC_W-1:0] pc_next;
  frb_pkg::ctrl_word_t    cw;
  logic                   cond_true;
  logic                   is_emit;
  logic                   slot_free;
  logic                   stall;

  logic [frb_pkg::KIND_W-1:0] kind;
  logic [POS_BITS-1:0]    pos;
  logic [POS_BITS-1:0]    prev;
  logic [POS_BITS-1:0]    cur;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       lim;
  logic                   n1;
  logic                   clip;

  logic [7:0]             s_eff;
  logic [7:0]             f_eff;
  logic                   above;
  logic [POS_BITS-1:0]    gap;
  logic                   n1_load;
  logic [POS_BITS-1:0]    cur_load;
  logic [CNT_W-1:0]       lim_load;
  logic                   gt;
  logic                   more;
  logic                   kind_none;

  logic                   o_valid;
  logic [POS_BITS-1:0]    o_pos;
  logic                   o_orig;
  logic                   o_last;
  logic                   o_clip;

  assign reg_sel   = paddr[3:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride          <= frb_pkg::STRIDE_RESET;
      first_stride    <= frb_pkg::FIRST_STRIDE_RESET;
      first_step_mode <= frb_pkg::FIRST_MODE_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        frb_pkg::REG_STRIDE:       stride          <= pwdata[7:0];
        frb_pkg::REG_FIRST_STRIDE: first_stride    <= pwdata[7:0];
        frb_pkg::REG_FIRST_MODE:   first_step_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      frb_pkg::REG_STRIDE:       prdata = {{(frb_pkg::DATA_W-8){1'b0}}, stride};
      frb_pkg::REG_FIRST_STRIDE: prdata = {{(frb_pkg::DATA_W-8){1'b0}}, first_stride};
      frb_pkg::REG_FIRST_MODE:   prdata = {{(frb_pkg::DATA_W-1){1'b0}}, first_step_mode};
      default:                   prdata = '0;
    endcase
  end

  assign s_eff = (stride == 8'd0) ? 8'd1 : stride;
  assign f_eff = (first_stride == 8'd0) ? 8'd1 : first_stride;

  assign above    = boundary.position > prev;
  assign gap      = boundary.position - prev;
  assign n1_load  = first_step_mode && (boundary.kind == frb_pkg::KIND_LATER) && above &&
                    (gap > POS_BITS'(f_eff));
  assign cur_load = n1_load ? (boundary.position - POS_BITS'(f_eff)) : boundary.position;
  assign lim_load = (boundary.kind == frb_pkg::KIND_LATER) ?
                    (CNT_W'(MAX_RUN - 1) - CNT_W'(n1_load)) : CNT_W'(MAX_RUN);

  assign gt   = {1'b0, cur} > ({1'b0, prev} + (POS_BITS + 1)'(s_eff));
  assign more = gt && (cnt != lim);

  always_comb begin
    kind_none = 1'b1;
    if (kind inside {frb_pkg::KIND_FIRST, frb_pkg::KIND_LATER, frb_pkg::KIND_LENGTH}) begin
      kind_none = 1'b0;
    end
  end

  assign cw        = frb_pkg::ucode_rom(pc);
  assign slot_free = !o_valid || split.ready;
  assign is_emit   = (cw.op == frb_pkg::OP_EMIT_RUN) || (cw.op == frb_pkg::OP_EMIT_CUR) ||
                     (cw.op == frb_pkg::OP_EMIT_BOUND) || (cw.op == frb_pkg::OP_EMIT_ZERO);
  assign stall     = is_emit && !slot_free;

  always_comb begin
    case (cw.cond)
      frb_pkg::COND_NEVER:      cond_true = 1'b0;
      frb_pkg::COND_ALWAYS:     cond_true = 1'b1;
      frb_pkg::COND_NO_IN:      cond_true = !boundary.valid;
      frb_pkg::COND_KIND_FIRST: cond_true = kind == frb_pkg::KIND_FIRST;
      frb_pkg::COND_KIND_NONE:  cond_true = kind_none;
      frb_pkg::COND_MORE:       cond_true = more;
      frb_pkg::COND_CNT_ZERO:   cond_true = cnt == '0;
      frb_pkg::COND_RUN_MORE:   cond_true = cnt != CNT_W'(1);
      frb_pkg::COND_LENGTH:     cond_true = kind == frb_pkg::KIND_LENGTH;
      frb_pkg::COND_NO_N1:      cond_true = !n1;
      default:                  cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + frb_pkg::PC_W'(1);
    end
  end

  assign boundary.ready = (cw.op == frb_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= frb_pkg::PC_IDLE;
      prev <= '0;
      cnt  <= '0;
      lim  <= '0;
    end else begin
      pc <= pc_next;
      case (cw.op)
        frb_pkg::OP_LOAD: begin
          if (boundary.valid) begin
            kind <= boundary.kind;
            pos  <= boundary.position;
            cur  <= cur_load;
            n1   <= n1_load;
            lim  <= lim_load;
            cnt  <= '0;
            clip <= 1'b0;
          end
        end
        frb_pkg::OP_COUNT: begin
          if (more) begin
            cur <= cur - POS_BITS'(s_eff);
            cnt <= cnt + CNT_W'(1);
          end else begin
            clip <= gt;
          end
        end
        frb_pkg::OP_EMIT_RUN: begin
          if (slot_free) begin
            cur <= cur + POS_BITS'(s_eff);
            cnt <= cnt - CNT_W'(1);
          end
        end
        frb_pkg::OP_EMIT_BOUND, frb_pkg::OP_EMIT_ZERO: begin
          if (slot_free) begin
            prev <= pos;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (is_emit && slot_free) begin
      o_valid <= 1'b1;
    end else if (split.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit && slot_free) begin
      case (cw.op)
        frb_pkg::OP_EMIT_RUN: begin
          o_pos  <= cur;
          o_orig <= 1'b0;
          o_last <= (kind == frb_pkg::KIND_LENGTH) && (cnt == CNT_W'(1));
          o_clip <= clip;
        end
        frb_pkg::OP_EMIT_CUR: begin
          o_pos  <= cur;
          o_orig <= 1'b0;
          o_last <= 1'b0;
          o_clip <= clip;
        end
        frb_pkg::OP_EMIT_BOUND: begin
          o_pos  <= pos;
          o_orig <= 1'b1;
          o_last <= 1'b1;
          o_clip <= clip;
        end
        default: begin
          o_pos  <= '0;
          o_orig <= 1'b1;
          o_last <= 1'b1;
          o_clip <= 1'b0;
        end
      endcase
    end
  end

  assign split.valid          = o_valid;
  assign split.split_position = o_pos;
  assign split.is_original    = o_orig;
  assign split.last           = o_last;
  assign split.clipped        = o_clip;

  `FBR_ASSERT_IMPLY(a_cnt_within_limit, 1'b1, cnt <= lim)
  `FBR_ASSERT_IMPLY(a_original_is_last, split.valid && split.is_original, split.last)
  `FBR_ASSERT_IMPLY(a_artificial_above_prev, split.valid && !split.is_original,
                    split.split_position > prev)
  `FBR_ASSERT_NEXT(a_one_item_at_a_time, boundary.valid && boundary.ready, !boundary.ready)

endmodule
